### hw/rtl/ecl_pkg.sv
// Shared types and constants for the expression character lexer.
`default_nettype none

package ecl_pkg;

  // Token kinds as they appear on the result channel
  typedef enum logic [3:0] {
    TK_PLUS            = 4'd0,
    TK_MINUS           = 4'd1,
    TK_MUL             = 4'd2,
    TK_DIV             = 4'd3,
    TK_LPAREN          = 4'd4,
    TK_RPAREN          = 4'd5,
    TK_PRINT           = 4'd6,
    TK_ASSIGN          = 4'd7,
    TK_INT             = 4'd8,
    TK_REAL            = 4'd9,
    TK_VAR             = 4'd10,
    TK_END             = 4'd11,
    TK_SYNTAX_ERR      = 4'd12,
    TK_BAD_CHAR        = 4'd13,
    TK_PRINT_MISPLACED = 4'd14,
    TK_TOO_LONG        = 4'd15
  } tok_kind_t;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUERY  = 8'h3F;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // Tokens produced by one character, and the queue that holds them
  localparam int BUNDLE_MAX = 3;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    tok_kind_t   token_kind;
    logic [7:0]  token_start;
    logic [6:0]  token_length;
    logic [31:0] int_value;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  start;
    logic [6:0]  length;
    logic [31:0] value;
  } tok_t;

  typedef struct packed {
    logic [1:0]                 count;
    tok_t [BUNDLE_MAX-1:0]      toks;
  } bundle_t;

endpackage

`default_nettype wire

### hw/rtl/expression_char_lexer_core.sv
// Top level of the expression character lexer.
`default_nettype none

// Streaming lexer for one arithmetic expression line, one character per request on
// in_*. Each character is taken while the four-entry bundle queue has room; the
// front end classifies it and queues the one to three tokens it causes, if any,
// as one bundle. The output sequencer sends one token per cycle while out_ready
// is high from a registered output stage, marking the last token of a character
// with run_last. Sustained rate is one character per cycle when characters cause
// at most one token each and out_ready stays high; else the output stage limits
// it. The last character of a line (line_end) closes any pending token and, unless
// in error, adds an end marker; after an error the rest of the line gives no tokens.
module expression_char_lexer_core #(
  parameter int MAX_LINE      = 256,
  parameter int MAX_TOKEN_LEN = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  ecl_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output ecl_pkg::out_item_t  out_data
);

  logic               accept;
  logic               push;
  logic               pop;
  logic               q_empty;
  logic               q_full;
  ecl_pkg::bundle_t   push_data;
  ecl_pkg::bundle_t   head;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  ecl_front #(
    .MAX_LINE      (MAX_LINE),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept_i  (accept),
    .in_data_i (in_data),
    .push_o    (push),
    .bundle_o  (push_data)
  );

  ecl_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  ecl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_i    (head),
    .empty_i   (q_empty),
    .pop_o     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hw/rtl/ecl_front.sv
// Front end: classifies each character, updates the scan state, builds a token bundle.
`default_nettype none

module ecl_front #(
  parameter int MAX_LINE      = 256,
  parameter int MAX_TOKEN_LEN = 64
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  accept_i,
  input  ecl_pkg::in_item_t    in_data_i,
  output logic                 push_o,
  output ecl_pkg::bundle_t     bundle_o
);

  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int TW = $clog2(MAX_TOKEN_LEN + 1);

  typedef enum logic [1:0] {
    M_IDLE,
    M_VAR,
    M_CONST,
    M_ERR
  } mode_t;

  typedef struct packed {
    logic          hit;
    ecl_pkg::tok_t tok;
    logic          err;
  } flush_t;

  typedef struct packed {
    logic          hit;
    ecl_pkg::tok_t tok;
    mode_t         mode;
    logic          begin_tok;
  } fresh_t;

  mode_t            mode_r,  mode_nxt;
  logic [LW-1:0]    pos_r,   pos_nxt;
  logic [LW-1:0]    start_r, start_nxt;
  logic [TW-1:0]    len_r,   len_nxt;
  logic [31:0]      acc_r,   acc_nxt;
  logic             dot_r,   dot_nxt;

  ecl_pkg::tok_t [ecl_pkg::BUNDLE_MAX-1:0] toks;
  logic [1:0]       n_v;
  flush_t           fl_mid;
  flush_t           fl_end;
  fresh_t           fr;
  logic [35:0]      acc_x10;
  logic [31:0]      acc_sat;
  logic [7:0]       c;
  logic             last;

  function automatic logic is_space(logic [7:0] ch);
    return (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
  endfunction

  function automatic logic is_alpha(logic [7:0] ch);
    return (ch >= 8'd65 && ch <= 8'd90) || (ch >= 8'd97 && ch <= 8'd122);
  endfunction

  function automatic logic is_digit(logic [7:0] ch);
    return ch >= 8'd48 && ch <= 8'd57;
  endfunction

  function automatic logic is_op(logic [7:0] ch);
    return (ch == ecl_pkg::CH_PLUS) || (ch == ecl_pkg::CH_MINUS) ||
           (ch == ecl_pkg::CH_STAR) || (ch == ecl_pkg::CH_SLASH) ||
           (ch == ecl_pkg::CH_LPAREN) || (ch == ecl_pkg::CH_RPAREN);
  endfunction

  function automatic ecl_pkg::tok_kind_t op_kind(logic [7:0] ch);
    ecl_pkg::tok_kind_t k;
    unique case (ch)
      ecl_pkg::CH_PLUS:   k = ecl_pkg::TK_PLUS;
      ecl_pkg::CH_MINUS:  k = ecl_pkg::TK_MINUS;
      ecl_pkg::CH_STAR:   k = ecl_pkg::TK_MUL;
      ecl_pkg::CH_SLASH:  k = ecl_pkg::TK_DIV;
      ecl_pkg::CH_LPAREN: k = ecl_pkg::TK_LPAREN;
      default:            k = ecl_pkg::TK_RPAREN;
    endcase
    return k;
  endfunction

  // Saturate start at 255 and length at 127 as the result fields demand
  function automatic ecl_pkg::tok_t mk_tok(ecl_pkg::tok_kind_t k, logic [31:0] s,
                                           logic [31:0] l, logic [31:0] v);
    ecl_pkg::tok_t t;
    t.kind   = k;
    t.start  = (s > 32'd255) ? 8'hFF : s[7:0];
    t.length = (l > 32'd127) ? 7'h7F : l[6:0];
    t.value  = v;
    return t;
  endfunction

  function automatic flush_t flush_f(mode_t m, logic [LW-1:0] s, logic [TW-1:0] l,
                                     logic [31:0] a, logic d);
    flush_t r;
    r = '0;
    if (m == M_VAR) begin
      r.hit = 1'b1;
      r.err = d;
      r.tok = mk_tok(d ? ecl_pkg::TK_SYNTAX_ERR : ecl_pkg::TK_VAR, 32'(s), 32'(l), 32'd0);
    end else if (m == M_CONST) begin
      r.hit = 1'b1;
      r.tok = mk_tok(d ? ecl_pkg::TK_REAL : ecl_pkg::TK_INT, 32'(s), 32'(l),
                     d ? 32'd0 : a);
    end
    return r;
  endfunction

  function automatic fresh_t fresh_f(logic [7:0] ch, logic [LW-1:0] p);
    fresh_t r;
    r      = '0;
    r.mode = M_IDLE;
    if (!is_space(ch)) begin
      priority if (is_alpha(ch) || ch == ecl_pkg::CH_UNDER) begin
        r.mode      = M_VAR;
        r.begin_tok = 1'b1;
      end else if (is_digit(ch)) begin
        r.mode      = M_CONST;
        r.begin_tok = 1'b1;
      end else if (is_op(ch)) begin
        r.hit = 1'b1;
        r.tok = mk_tok(op_kind(ch), 32'(p), 32'd1, 32'd0);
      end else if (ch == ecl_pkg::CH_QUERY) begin
        r.hit = 1'b1;
        if (p == '0) begin
          r.tok = mk_tok(ecl_pkg::TK_PRINT, 32'(p), 32'd1, 32'd0);
        end else begin
          r.tok  = mk_tok(ecl_pkg::TK_PRINT_MISPLACED, 32'(p), 32'd1, 32'd0);
          r.mode = M_ERR;
        end
      end else if (ch == ecl_pkg::CH_EQUALS) begin
        r.hit = 1'b1;
        r.tok = mk_tok(ecl_pkg::TK_ASSIGN, 32'(p), 32'd1, 32'd0);
      end else begin
        r.hit  = 1'b1;
        r.tok  = mk_tok(ecl_pkg::TK_BAD_CHAR, 32'(p), 32'd1, 32'd0);
        r.mode = M_ERR;
      end
    end
    return r;
  endfunction

  assign c    = in_data_i.char_in;
  assign last = in_data_i.line_end;

  assign fl_mid  = flush_f(mode_r, start_r, len_r, acc_r, dot_r);
  assign fr      = fresh_f(c, pos_r);
  assign acc_x10 = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {32'b0, c[3:0]};
  assign acc_sat = (acc_x10[35:32] != 4'b0) ? 32'hFFFF_FFFF : acc_x10[31:0];

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    dot_nxt   = dot_r;
    toks      = '0;
    n_v       = 2'd0;
    fl_end    = '0;

    if (mode_r != M_ERR) begin
      if (pos_r >= LW'(MAX_LINE)) begin
        toks[n_v] = mk_tok(ecl_pkg::TK_TOO_LONG, 32'(pos_r), 32'd0, 32'd0);
        n_v       = n_v + 2'd1;
        mode_nxt  = M_ERR;
      end else if ((mode_r == M_VAR && (is_alpha(c) || is_digit(c) ||
                    c == ecl_pkg::CH_UNDER || c == ecl_pkg::CH_DOT)) ||
                   (mode_r == M_CONST && (is_digit(c) || c == ecl_pkg::CH_DOT))) begin
        // grow the pending token, or report it as too long once it holds MAX_TOKEN_LEN characters
        if (len_r >= TW'(MAX_TOKEN_LEN)) begin
          toks[n_v] = mk_tok(ecl_pkg::TK_TOO_LONG, 32'(start_r), 32'(MAX_TOKEN_LEN), 32'd0);
          n_v       = n_v + 2'd1;
          mode_nxt  = M_ERR;
        end else begin
          len_nxt = len_r + TW'(1);
        end
        if (c == ecl_pkg::CH_DOT) begin
          dot_nxt = 1'b1;
        end else if (mode_r == M_CONST) begin
          acc_nxt = acc_sat;
        end
      end else if (mode_r == M_CONST && !(is_op(c) || is_space(c))) begin
        toks[n_v] = mk_tok(ecl_pkg::TK_SYNTAX_ERR, 32'(start_r), 32'(len_r) + 32'd1, 32'd0);
        n_v       = n_v + 2'd1;
        mode_nxt  = M_ERR;
      end else begin
        // close any pending token, then, unless it was an error, treat the character as a fresh start
        if (fl_mid.hit) begin
          toks[n_v] = fl_mid.tok;
          n_v       = n_v + 2'd1;
        end
        if (fl_mid.err) begin
          mode_nxt = M_ERR;
        end else begin
          mode_nxt = fr.mode;
          if (fr.hit) begin
            toks[n_v] = fr.tok;
            n_v       = n_v + 2'd1;
          end
          if (fr.begin_tok) begin
            start_nxt = pos_r;
            len_nxt   = TW'(1);
            dot_nxt   = 1'b0;
            acc_nxt   = {28'b0, c[3:0]};
          end
        end
      end

      if (pos_r < LW'(MAX_LINE)) begin
        pos_nxt = pos_r + LW'(1);
      end

      if (last && mode_nxt != M_ERR) begin
        fl_end = flush_f(mode_nxt, start_nxt, len_nxt, acc_nxt, dot_nxt);
        if (fl_end.hit) begin
          toks[n_v] = fl_end.tok;
          n_v       = n_v + 2'd1;
        end
        if (!fl_end.err) begin
          toks[n_v] = mk_tok(ecl_pkg::TK_END, 32'(pos_r) + 32'd1, 32'd0, 32'd0);
          n_v       = n_v + 2'd1;
        end
      end
    end

    // the line end clears the scan state for the next line
    if (last) begin
      mode_nxt  = M_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
      acc_nxt   = '0;
      dot_nxt   = 1'b0;
    end
  end

  assign push_o         = accept_i && (n_v != 2'd0);
  assign bundle_o.count = n_v;
  assign bundle_o.toks  = toks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      acc_r   <= '0;
      dot_r   <= 1'b0;
    end else if (accept_i) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      acc_r   <= acc_nxt;
      dot_r   <= dot_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ecl_fifo.sv
// Short queue of token bundles between the front end and the output sequencer.
`default_nettype none

module ecl_fifo (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push_i,
  input  ecl_pkg::bundle_t   push_data_i,
  input  wire                pop_i,
  output ecl_pkg::bundle_t   head_o,
  output logic               empty_o,
  output logic               full_o
);

  ecl_pkg::bundle_t               mem_r [ecl_pkg::QDEPTH];
  logic [ecl_pkg::QPTR_W-1:0]     wr_r;
  logic [ecl_pkg::QPTR_W-1:0]     rd_r;
  logic [ecl_pkg::QCNT_W-1:0]     cnt_r;

  assign head_o  = mem_r[rd_r];
  assign empty_o = (cnt_r == '0);
  assign full_o  = (cnt_r == ecl_pkg::QCNT_W'(ecl_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_r] <= push_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) begin
        wr_r <= wr_r + ecl_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_r <= rd_r + ecl_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_r <= cnt_r + ecl_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_r <= cnt_r - ecl_pkg::QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("bundle queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("bundle queue read while empty");

  a_nonempty_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (push_data_i.count != 2'd0))
    else $error("empty token bundle queued");

endmodule

`default_nettype wire

### hw/rtl/ecl_back.sv
// Output sequencer: sends the tokens of each queued bundle one per cycle while out_ready is high.
`default_nettype none

module ecl_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ecl_pkg::bundle_t    head_i,
  input  wire                 empty_i,
  output logic                pop_o,
  output logic                out_valid,
  input  wire                 out_ready,
  output ecl_pkg::out_item_t  out_data
);

  logic                 idx_r;
  logic [1:0]           sel_r;
  logic                 load;
  logic                 final_tok;
  ecl_pkg::tok_t        tok;
  logic                 out_valid_r;
  ecl_pkg::out_item_t   out_data_r;

  assign load      = !empty_i && (!out_valid_r || out_ready);
  assign tok       = head_i.toks[sel_r];
  assign final_tok = (sel_r == head_i.count - 2'd1);
  assign pop_o     = load && final_tok;

  // sel_r walks the tokens of the head bundle; idx_r marks that the walk is under way
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 2'd0;
      idx_r       <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sel_r       <= final_tok ? 2'd0 : sel_r + 2'd1;
        idx_r       <= !final_tok;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load) begin
      out_data_r.token_kind   <= tok.kind;
      out_data_r.token_start  <= tok.start;
      out_data_r.token_length <= tok.length;
      out_data_r.int_value    <= tok.value;
      out_data_r.run_last     <= final_tok;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_walk_flag: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r == (sel_r != 2'd0))
    else $error("token index and walk flag disagree");

endmodule

`default_nettype wire
